// ===== src/lcabl_pkg.sv =====
`timescale 1ns / 1ps
// shared types and constants for the binary lifting ancestor engine
// no dependencies

package lcabl_pkg;

    localparam int NODE_W  = 11;
    localparam int DEPTH_W = 11;
    localparam int RDIST_W = 26;
    localparam int DIST_W  = 27;
    localparam int WGT_W   = 16;
    localparam int STEP_W  = 10;

    localparam logic [DEPTH_W-1:0] DEPTH_CAP = '1;
    localparam logic [RDIST_W-1:0] RDIST_CAP = '1;

    typedef enum logic [2:0] {
        KIND_LOAD  = 3'd0,
        KIND_BUILD = 3'd1,
        KIND_LCA   = 3'd2,
        KIND_UP    = 3'd3,
        KIND_DIST  = 3'd4
    } kind_t;

    typedef enum logic [1:0] {
        CFG_INDEX_BASE = 2'd0,
        CFG_NODE_COUNT = 2'd1
    } cfg_index_t;

    typedef struct packed {
        logic [DEPTH_W-1:0] depth;
        logic [RDIST_W-1:0] rdist;
    } info_t;

endpackage

// ===== src/lca_binary_lifting_top.sv =====
`timescale 1ns / 1ps
// Rooted-tree ancestor engine (binary lifting): load, build, lca, go up, distance.
// Depends on lcabl_pkg and lcabl_anc_ram.
//
// One item at a time, one result beat per item. After reset the ancestor table
// is cleared one entry a cycle, with s_tready low. Each lca or distance lifting
// step is an ancestor table read plus, when a depth-equalising climb is taken, a
// depth read. A build makes three table port accesses per entry. Input is taken
// while a finished result waits on m_.

module lca_binary_lifting_top #(
    parameter int MAX_NODES = 1024,
    parameter int LIFT_LEVELS = 10,
    parameter int WEIGHT_BITS = 16
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [47:0] s_tdata,   // node_a, node_b, edge_weight, steps_up
    input  logic [3:0]  s_tuser,   // kind, is_root
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,   // result_node, distance, zero pad
    output logic [1:0]  m_tuser,   // found, error
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [10:0] cfg_data
);
    import lcabl_pkg::*;

    localparam int SLOT_W = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
    localparam int LVL_W  = (LIFT_LEVELS > 1) ? $clog2(LIFT_LEVELS) : 1;
    localparam logic [16:0] MAXN17 = 17'(MAX_NODES);
    localparam logic [SLOT_W-1:0] SLOT_LAST = SLOT_W'(MAX_NODES - 1);
    localparam logic [LVL_W-1:0] LVL_LAST = LVL_W'(LIFT_LEVELS - 1);
    localparam logic [4:0] LVL_CNT = 5'(LIFT_LEVELS);
    localparam logic [WGT_W-1:0] W_MASK =
        (WEIGHT_BITS >= WGT_W) ? '1 : WGT_W'((1 << WEIGHT_BITS) - 1);

    typedef enum logic [20:0] {
        ST_CLEAR = 21'h000001,
        ST_IDLE  = 21'h000002,
        ST_LD_WR = 21'h000004,
        ST_B_R1  = 21'h000008,
        ST_B_R2  = 21'h000010,
        ST_B_WR  = 21'h000020,
        ST_Q_RB  = 21'h000040,
        ST_Q_SW  = 21'h000080,
        ST_C1_R  = 21'h000100,
        ST_C1_U  = 21'h000200,
        ST_C1_D  = 21'h000400,
        ST_EQ    = 21'h000800,
        ST_C2_R  = 21'h001000,
        ST_C2_U  = 21'h002000,
        ST_F_R   = 21'h004000,
        ST_F_U   = 21'h008000,
        ST_L_D   = 21'h010000,
        ST_U_CHK = 21'h020000,
        ST_U_UPD = 21'h040000,
        ST_DONE  = 21'h080000,
        ST_SPARE = 21'h100000
    } state_t;

    // input fields
    logic [NODE_W-1:0] in_a, in_b;
    logic [WGT_W-1:0]  in_w;
    logic [STEP_W-1:0] in_k;
    kind_t             in_kind;
    logic              in_root;
    assign in_a    = s_tdata[10:0];
    assign in_b    = s_tdata[21:11];
    assign in_w    = s_tdata[37:22];
    assign in_k    = s_tdata[47:38];
    assign in_kind = kind_t'(s_tuser[2:0]);
    assign in_root = s_tuser[3];

    state_t state_reg, state_next;
    logic              base_reg, base_next;
    logic [10:0]       count_reg, count_next;
    kind_t             kind_reg, kind_next;
    logic              root_reg, root_next;
    logic [WGT_W-1:0]  w_reg, w_next;
    logic [SLOT_W-1:0] a_reg, a_next, b_reg, b_next, slot_reg, slot_next;
    logic [DEPTH_W-1:0] da_reg, da_next, db_reg, db_next;
    logic [RDIST_W-1:0] ra_reg, ra_next, rb_reg, rb_next;
    logic [STEP_W-1:0] k_reg, k_next;
    logic [3:0]        gi_reg, gi_next;
    logic [LVL_W-1:0]  lvl_reg, lvl_next;
    logic              ok1_reg, ok1_next;
    logic [NODE_W-1:0] rnode_reg, rnode_next;
    logic              found_reg, found_next, err_reg, err_next;
    logic [DIST_W-1:0] dist_reg, dist_next;
    logic              mv_reg, mv_next;
    logic [39:0]       mdata_reg, mdata_next;
    logic [1:0]        muser_reg, muser_next;

    // info memory: depth and root distance per slot
    info_t             info_mem [MAX_NODES];
    info_t             info_rd, info_wd;
    logic [SLOT_W-1:0] info_raddr;
    logic              info_we;

    always_ff @(posedge aclk) begin
        if (info_we) begin
            info_mem[a_reg] <= info_wd;
        end
        info_rd <= info_mem[info_raddr];
    end

    // ancestor table
    logic              t_we;
    logic [LVL_W-1:0]  t_wlvl, t_alvl;
    logic [SLOT_W-1:0] t_wslot, t_aslot;
    logic [SLOT_W:0]   t_wdata, t_adata, t_bdata;

    lcabl_anc_ram #(
        .LEVELS (LIFT_LEVELS),
        .DEPTH_N(MAX_NODES),
        .LVL_W  (LVL_W),
        .SLOT_W (SLOT_W)
    ) u_anc (
        .aclk  (aclk),
        .we    (t_we),
        .w_lvl (t_wlvl),
        .w_slot(t_wslot),
        .w_data(t_wdata),
        .a_lvl (t_alvl),
        .a_slot(t_aslot),
        .a_data(t_adata),
        .b_lvl (lvl_reg),
        .b_slot(b_reg),
        .b_data(t_bdata)
    );

    logic [SLOT_W-1:0] ta_slot, tb_slot;
    logic              ta_ok, tb_ok;
    assign ta_slot = t_adata[SLOT_W-1:0];
    assign ta_ok   = t_adata[SLOT_W];
    assign tb_slot = t_bdata[SLOT_W-1:0];
    assign tb_ok   = t_bdata[SLOT_W];

    // node number range check
    logic [16:0] cnt_eff;
    logic [16:0] off_a, off_b;
    logic        va, vb;
    assign cnt_eff = ({6'd0, count_reg} > MAXN17) ? MAXN17 : {6'd0, count_reg};
    assign off_a   = {6'd0, in_a} - {16'd0, base_reg};
    assign off_b   = {6'd0, in_b} - {16'd0, base_reg};
    assign va = (in_a >= {10'd0, base_reg}) && (off_a < cnt_eff);
    assign vb = (in_b >= {10'd0, base_reg}) && (off_b < cnt_eff);

    // arithmetic helpers
    logic [DEPTH_W:0]   d_inc;
    logic [RDIST_W:0]   r_inc;
    logic [16:0]        need_d;
    logic [DIST_W:0]    dsum;
    assign d_inc  = {1'b0, info_rd.depth} + 1'b1;
    assign r_inc  = {1'b0, info_rd.rdist} + {{(RDIST_W+1-WGT_W){1'b0}}, w_reg & W_MASK};
    assign need_d = {6'd0, db_reg} + (17'd1 << lvl_reg);
    assign dsum   = {2'b0, ra_reg} + {2'b0, rb_reg} - {1'b0, info_rd.rdist, 1'b0};

    assign s_tready  = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;
    assign m_tvalid  = mv_reg;
    assign m_tdata   = mdata_reg;
    assign m_tuser   = muser_reg;

    always_comb begin
        state_next = state_reg;
        base_next  = base_reg;
        count_next = count_reg;
        kind_next  = kind_reg;
        root_next  = root_reg;
        w_next     = w_reg;
        a_next     = a_reg;
        b_next     = b_reg;
        slot_next  = slot_reg;
        da_next    = da_reg;
        db_next    = db_reg;
        ra_next    = ra_reg;
        rb_next    = rb_reg;
        k_next     = k_reg;
        gi_next    = gi_reg;
        lvl_next   = lvl_reg;
        ok1_next   = ok1_reg;
        rnode_next = rnode_reg;
        found_next = found_reg;
        err_next   = err_reg;
        dist_next  = dist_reg;
        mv_next    = mv_reg;
        mdata_next = mdata_reg;
        muser_next = muser_reg;
        info_raddr = a_reg;
        info_we    = 1'b0;
        info_wd    = '0;
        t_we       = 1'b0;
        t_wlvl     = lvl_reg;
        t_wslot    = slot_reg;
        t_wdata    = '0;
        t_alvl     = lvl_reg;
        t_aslot    = a_reg;

        if (mv_reg && m_tready) begin
            mv_next = 1'b0;
        end

        if (cfg_valid) begin
            unique case (cfg_index)
                CFG_INDEX_BASE: base_next  = cfg_data[0];
                CFG_NODE_COUNT: count_next = cfg_data;
                default: ;
            endcase
        end

        unique case (state_reg)
            ST_CLEAR: begin
                t_we = 1'b1;
                slot_next = slot_reg + 1'b1;
                if (slot_reg == SLOT_LAST) begin
                    slot_next = '0;
                    lvl_next  = lvl_reg + 1'b1;
                    if (lvl_reg == LVL_LAST) begin
                        state_next = ST_IDLE;
                    end
                end
            end
            ST_IDLE: begin
                info_raddr = (in_kind == KIND_LOAD) ? SLOT_W'(off_b) : SLOT_W'(off_a);
                if (s_tvalid) begin
                    kind_next  = in_kind;
                    root_next  = in_root;
                    w_next     = in_w;
                    a_next     = SLOT_W'(off_a);
                    b_next     = SLOT_W'(off_b);
                    k_next     = in_k;
                    gi_next    = '0;
                    rnode_next = '0;
                    found_next = 1'b0;
                    err_next   = 1'b0;
                    dist_next  = '0;
                    state_next = ST_DONE;
                    unique case (in_kind)
                        KIND_LOAD: begin
                            if (!va || (!in_root && !vb)) err_next = 1'b1;
                            else state_next = ST_LD_WR;
                        end
                        KIND_BUILD: begin
                            if (LIFT_LEVELS > 1) begin
                                lvl_next   = LVL_W'(1);
                                slot_next  = '0;
                                state_next = ST_B_R1;
                            end
                        end
                        KIND_LCA, KIND_DIST: begin
                            if (!va || !vb) err_next = 1'b1;
                            else state_next = ST_Q_RB;
                        end
                        KIND_UP: begin
                            if (!va) err_next = 1'b1;
                            else state_next = ST_U_CHK;
                        end
                        default: ;
                    endcase
                end
            end
            ST_LD_WR: begin
                info_we = 1'b1;
                t_we    = 1'b1;
                t_wlvl  = '0;
                t_wslot = a_reg;
                if (root_reg) begin
                    info_wd = '{depth: DEPTH_W'(1), rdist: '0};
                end else begin
                    info_wd.depth = d_inc[DEPTH_W] ? DEPTH_CAP : d_inc[DEPTH_W-1:0];
                    info_wd.rdist = r_inc[RDIST_W] ? RDIST_CAP : r_inc[RDIST_W-1:0];
                    t_wdata = {1'b1, b_reg};
                end
                state_next = ST_DONE;
            end
            ST_B_R1: begin
                t_alvl  = lvl_reg - 1'b1;
                t_aslot = slot_reg;
                state_next = ST_B_R2;
            end
            ST_B_R2: begin
                ok1_next = ta_ok;
                t_alvl   = lvl_reg - 1'b1;
                t_aslot  = ta_slot;
                state_next = ST_B_WR;
            end
            ST_B_WR: begin
                t_we    = 1'b1;
                t_wdata = (ok1_reg && ta_ok) ? {1'b1, ta_slot} : '0;
                slot_next  = slot_reg + 1'b1;
                state_next = ST_B_R1;
                if (slot_reg == SLOT_LAST) begin
                    slot_next = '0;
                    lvl_next  = lvl_reg + 1'b1;
                    if (lvl_reg == LVL_LAST) state_next = ST_DONE;
                end
            end
            ST_Q_RB: begin
                da_next    = info_rd.depth;
                ra_next    = info_rd.rdist;
                info_raddr = b_reg;
                state_next = ST_Q_SW;
            end
            ST_Q_SW: begin
                rb_next = info_rd.rdist;
                if (info_rd.depth > da_reg) begin
                    a_next  = b_reg;
                    b_next  = a_reg;
                    da_next = info_rd.depth;
                    db_next = da_reg;
                end else begin
                    db_next = info_rd.depth;
                end
                lvl_next   = LVL_LAST;
                state_next = ST_C1_R;
            end
            ST_C1_R: state_next = ST_C1_U;
            ST_C1_U: begin
                info_raddr = ta_slot;
                if (ta_ok && ({6'd0, da_reg} >= need_d)) begin
                    a_next     = ta_slot;
                    state_next = ST_C1_D;
                end else if (lvl_reg == '0) begin
                    state_next = ST_EQ;
                end else begin
                    lvl_next   = lvl_reg - 1'b1;
                    state_next = ST_C1_R;
                end
            end
            ST_C1_D: begin
                da_next = info_rd.depth;
                if (lvl_reg == '0) begin
                    state_next = ST_EQ;
                end else begin
                    lvl_next   = lvl_reg - 1'b1;
                    state_next = ST_C1_R;
                end
            end
            ST_EQ: begin
                info_raddr = a_reg;
                if (a_reg == b_reg) begin
                    found_next = 1'b1;
                    rnode_next = (kind_reg == KIND_LCA) ?
                                 NODE_W'(a_reg) + {10'd0, base_reg} : '0;
                    state_next = (kind_reg == KIND_LCA) ? ST_DONE : ST_L_D;
                end else begin
                    lvl_next   = LVL_LAST;
                    state_next = ST_C2_R;
                end
            end
            ST_C2_R: state_next = ST_C2_U;
            ST_C2_U: begin
                if (ta_ok && tb_ok && (ta_slot != tb_slot)) begin
                    a_next = ta_slot;
                    b_next = tb_slot;
                end
                if (lvl_reg == '0) begin
                    state_next = ST_F_R;
                end else begin
                    lvl_next   = lvl_reg - 1'b1;
                    state_next = ST_C2_R;
                end
            end
            ST_F_R: begin
                t_alvl     = '0;
                state_next = ST_F_U;
            end
            ST_F_U: begin
                info_raddr = ta_slot;
                if (!ta_ok) begin
                    state_next = ST_DONE;
                end else begin
                    found_next = 1'b1;
                    rnode_next = (kind_reg == KIND_LCA) ?
                                 NODE_W'(ta_slot) + {10'd0, base_reg} : '0;
                    state_next = (kind_reg == KIND_LCA) ? ST_DONE : ST_L_D;
                end
            end
            ST_L_D: begin
                dist_next  = dsum[DIST_W] ? '0 : dsum[DIST_W-1:0];
                state_next = ST_DONE;
            end
            ST_U_CHK: begin
                t_alvl = gi_reg[LVL_W-1:0];
                if (k_reg == '0) begin
                    found_next = 1'b1;
                    rnode_next = NODE_W'(a_reg) + {10'd0, base_reg};
                    state_next = ST_DONE;
                end else if (k_reg[0]) begin
                    if ({1'b0, gi_reg} >= LVL_CNT) state_next = ST_DONE;
                    else state_next = ST_U_UPD;
                end else begin
                    k_next  = k_reg >> 1;
                    gi_next = gi_reg + 1'b1;
                end
            end
            ST_U_UPD: begin
                if (!ta_ok) begin
                    state_next = ST_DONE;
                end else begin
                    a_next     = ta_slot;
                    k_next     = k_reg >> 1;
                    gi_next    = gi_reg + 1'b1;
                    state_next = ST_U_CHK;
                end
            end
            ST_DONE: begin
                if (!mv_reg || m_tready) begin
                    mv_next    = 1'b1;
                    mdata_next = {2'b00, dist_reg, rnode_reg};
                    muser_next = {err_reg, found_reg};
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_CLEAR;
            base_reg  <= 1'b0;
            count_reg <= 11'd1024;
            lvl_reg   <= '0;
            slot_reg  <= '0;
            mv_reg    <= 1'b0;
        end else begin
            state_reg <= state_next;
            base_reg  <= base_next;
            count_reg <= count_next;
            lvl_reg   <= lvl_next;
            slot_reg  <= slot_next;
            mv_reg    <= mv_next;
        end
    end

    always_ff @(posedge aclk) begin
        kind_reg  <= kind_next;
        root_reg  <= root_next;
        w_reg     <= w_next;
        a_reg     <= a_next;
        b_reg     <= b_next;
        da_reg    <= da_next;
        db_reg    <= db_next;
        ra_reg    <= ra_next;
        rb_reg    <= rb_next;
        k_reg     <= k_next;
        gi_reg    <= gi_next;
        ok1_reg   <= ok1_next;
        rnode_reg <= rnode_next;
        found_reg <= found_next;
        err_reg   <= err_next;
        dist_reg  <= dist_next;
        mdata_reg <= mdata_next;
        muser_reg <= muser_next;
    end

    a_clear_quiet: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_CLEAR) |-> !mv_reg)
        else $error("result beat during table clear");

    a_accept_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> (state_reg != ST_IDLE))
        else $error("accepted beat left engine idle");

    a_flags_excl: assert property (@(posedge aclk) disable iff (!aresetn)
        mv_reg |-> !(muser_reg[0] && muser_reg[1]))
        else $error("found and error both set");

    a_dist_found: assert property (@(posedge aclk) disable iff (!aresetn)
        (mv_reg && (mdata_reg[37:11] != '0)) |-> muser_reg[0])
        else $error("distance without common ancestor");

endmodule

// ===== src/lcabl_anc_ram.sv =====
`timescale 1ns / 1ps
// ancestor table memory: one write port, two registered read ports
// entry is {has ancestor, ancestor slot}; no dependencies

module lcabl_anc_ram #(
    parameter int LEVELS = 10,
    parameter int DEPTH_N = 1024,
    parameter int LVL_W = 4,
    parameter int SLOT_W = 10
) (
    input  logic              aclk,
    input  logic              we,
    input  logic [LVL_W-1:0]  w_lvl,
    input  logic [SLOT_W-1:0] w_slot,
    input  logic [SLOT_W:0]   w_data,
    input  logic [LVL_W-1:0]  a_lvl,
    input  logic [SLOT_W-1:0] a_slot,
    output logic [SLOT_W:0]   a_data,
    input  logic [LVL_W-1:0]  b_lvl,
    input  logic [SLOT_W-1:0] b_slot,
    output logic [SLOT_W:0]   b_data
);

    logic [SLOT_W:0] mem [LEVELS][DEPTH_N];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[w_lvl][w_slot] <= w_data;
        end
        a_data <= mem[a_lvl][a_slot];
        b_data <= mem[b_lvl][b_slot];
    end

endmodule

// ===== dv/tb_top.sv =====
`timescale 1ns / 1ps
// self-checking testbench for lca_binary_lifting_top: random trees, builds and queries
// depends on lcabl_pkg and the lca_binary_lifting_top rtl

module tb_top;
    import lcabl_pkg::*;

    localparam int NODES  = 1024;
    localparam int LEVELS = 10;

    typedef struct {
        logic [2:0]        kind;
        logic [NODE_W-1:0] node_a;
        logic [NODE_W-1:0] node_b;
        logic              is_root;
        logic [WGT_W-1:0]  weight;
        logic [STEP_W-1:0] steps;
    } tree_op_t;

    typedef struct {
        logic [NODE_W-1:0] rnode;
        logic              found;
        logic [DIST_W-1:0] path_len;
        logic              err;
    } answer_t;

    class lca_scoreboard;
        logic [NODE_W-1:0]  anc[NODES][LEVELS];
        bit                 has_anc[NODES][LEVELS];
        logic [DEPTH_W-1:0] depth[NODES];
        logic [RDIST_W-1:0] rdist[NODES];
        bit                 loaded[NODES];
        bit                 base;
        int                 count;
        answer_t            pending[$];
        int                 mismatches;

        function new();
            base = 0;
            count = NODES;
            mismatches = 0;
            foreach (has_anc[i, j]) begin
                has_anc[i][j] = 0;
                anc[i][j] = '0;
            end
            foreach (loaded[i]) loaded[i] = 0;
        endfunction

        function bit in_range(int v);
            int c;
            c = count > NODES ? NODES : count;
            return v >= base && v - base < c;
        endfunction

        function bit find_lca(int a, int b, output int l);
            int t;
            if (depth[b] > depth[a]) begin
                t = a; a = b; b = t;
            end
            for (int i = LEVELS - 1; i >= 0; i--)
                if (has_anc[a][i] && int'(depth[a]) >= int'(depth[b]) + (1 << i))
                    a = anc[a][i];
            if (a == b) begin
                l = a;
                return 1;
            end
            for (int i = LEVELS - 1; i >= 0; i--)
                if (has_anc[a][i] && has_anc[b][i] && anc[a][i] != anc[b][i]) begin
                    a = anc[a][i];
                    b = anc[b][i];
                end
            l = anc[a][0];
            return has_anc[a][0];
        endfunction

        function void build_table();
            int p;
            for (int j = 1; j < LEVELS; j++)
                for (int i = 0; i < NODES; i++) begin
                    if (has_anc[i][j-1]) begin
                        p = anc[i][j-1];
                        has_anc[i][j] = has_anc[p][j-1];
                        anc[i][j] = has_anc[p][j-1] ? anc[p][j-1] : '0;
                    end else begin
                        has_anc[i][j] = 0;
                        anc[i][j] = '0;
                    end
                end
        endfunction

        function void note_item(tree_op_t op);
            answer_t r;
            int a, b, l, x, k;
            bit ok;
            longint s;
            r = '{default: '0};
            a = int'(op.node_a) - base;
            b = int'(op.node_b) - base;
            case (op.kind)
                KIND_LOAD: begin
                    if (!in_range(op.node_a) || (!op.is_root && !in_range(op.node_b))) begin
                        r.err = 1;
                    end else if (op.is_root) begin
                        has_anc[a][0] = 0;
                        anc[a][0] = '0;
                        depth[a] = 1;
                        rdist[a] = '0;
                        loaded[a] = 1;
                    end else begin
                        has_anc[a][0] = 1;
                        anc[a][0] = b;
                        s = depth[b] + 1;
                        depth[a] = s > DEPTH_CAP ? DEPTH_CAP : s;
                        s = longint'(rdist[b]) + op.weight;
                        rdist[a] = s > RDIST_CAP ? RDIST_CAP : s;
                        loaded[a] = 1;
                    end
                end
                KIND_BUILD: build_table();
                KIND_LCA, KIND_DIST: begin
                    if (!in_range(op.node_a) || !in_range(op.node_b)) begin
                        r.err = 1;
                    end else if (find_lca(a, b, l)) begin
                        r.found = 1;
                        if (op.kind == KIND_LCA) begin
                            r.rnode = l + base;
                        end else begin
                            s = longint'(rdist[a]) + rdist[b] - 2 * longint'(rdist[l]);
                            if (s < 0) s = 0;
                            if (s > 64'h7FFFFFF) s = 64'h7FFFFFF;
                            r.path_len = s;
                        end
                    end
                end
                KIND_UP: begin
                    if (!in_range(op.node_a)) begin
                        r.err = 1;
                    end else begin
                        k = op.steps;
                        x = a;
                        ok = 1;
                        for (int i = 0; k > 0 && ok; i++, k >>= 1)
                            if (k & 1) begin
                                if (i >= LEVELS || !has_anc[x][i]) ok = 0;
                                else x = anc[x][i];
                            end
                        if (ok) begin
                            r.found = 1;
                            r.rnode = x + base;
                        end
                    end
                end
                default: ;
            endcase
            pending.push_back(r);
        endfunction

        function void check_result(answer_t got);
            answer_t want;
            if (pending.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result beat: node %0d found %0b dist %0d err %0b",
                             got.rnode, got.found, got.path_len, got.err);
                return;
            end
            want = pending.pop_front();
            if (got.rnode !== want.rnode || got.found !== want.found ||
                got.path_len !== want.path_len || got.err !== want.err) begin
                mismatches++;
                if (mismatches <= 10)
                    $display({"result mismatch: exp node %0d found %0b dist %0d err %0b,",
                              " got node %0d found %0b dist %0d err %0b"},
                             want.rnode, want.found, want.path_len, want.err,
                             got.rnode, got.found, got.path_len, got.err);
            end
        endfunction
    endclass

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [47:0] s_tdata;
    logic [3:0]  s_tuser;
    logic        m_tvalid;
    logic        m_tready;
    logic [39:0] m_tdata;
    logic [1:0]  m_tuser;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [1:0]  cfg_index;
    logic [10:0] cfg_data;

    lca_scoreboard tree_sb;
    bit            idle_on;

    lca_binary_lifting_top DUT (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    always begin
        aclk = 1'b0;
        #5;
        aclk = 1'b1;
        #5;
    end

    initial begin
        #50ms;
        $display("lca_binary_lifting_top regression: fail");
        $finish;
    end

    task automatic send_op(tree_op_t op);
        int gap;
        gap = idle_on ? $urandom_range(0, 15) : 0;
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {op.steps, op.weight, op.node_b, op.node_a};
        s_tuser  <= {op.is_root, op.kind};
        do @(posedge aclk); while (!s_tready);
        tree_sb.note_item(op);
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (tree_sb.pending.size() != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);
    endtask

    task automatic write_reg(cfg_index_t idx, logic [10:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        if (idx == CFG_INDEX_BASE) tree_sb.base = value[0];
        else tree_sb.count = value;
    endtask

    task automatic set_range(bit b, int c);
        wait_drained();
        write_reg(CFG_INDEX_BASE, b);
        write_reg(CFG_NODE_COUNT, c);
    endtask

    // an 11-bit node number: out of range when bad, else a loaded node when there is one
    function automatic int pick_node(bit bad);
        int v, c;
        bit any;
        c = tree_sb.count > NODES ? NODES : tree_sb.count;
        any = 0;
        for (int i = 0; i < c; i++) if (tree_sb.loaded[i]) any = 1;
        if (bad || !any) begin
            do v = $urandom_range(0, 2047); while (tree_sb.in_range(v));
            return v;
        end
        do v = $urandom_range(0, c - 1); while (!tree_sb.loaded[v]);
        return v + tree_sb.base;
    endfunction

    function automatic tree_op_t load_op(int node, int parent, bit root, int w);
        tree_op_t op;
        op = '{kind: KIND_LOAD, node_a: node, node_b: parent, is_root: root,
               weight: w, steps: $urandom};
        return op;
    endfunction

    function automatic tree_op_t query_op(logic [2:0] kind, int a, int b, int k);
        tree_op_t op;
        op = '{kind: kind, node_a: a, node_b: b, is_root: $urandom,
               weight: $urandom, steps: k};
        return op;
    endfunction

    // random load: an in-range non-root load always takes a loaded node as its parent
    function automatic tree_op_t random_load();
        int c, s, p;
        c = tree_sb.count > NODES ? NODES : tree_sb.count;
        if (c == 0 || $urandom_range(0, 19) == 0)
            return load_op(pick_node(1), $urandom_range(0, 2047), $urandom, $urandom);
        s = $urandom_range(0, c - 1);
        p = -1;
        if ($urandom_range(0, 7) != 0)
            for (int t = 0; t < 20 && p < 0; t++) begin
                p = $urandom_range(0, c - 1);
                if (!tree_sb.loaded[p] || p == s) p = -1;
            end
        if (p < 0) return load_op(s + tree_sb.base, $urandom_range(0, 2047), 1, $urandom);
        return load_op(s + tree_sb.base, p + tree_sb.base, 0,
                       $urandom_range(0, 3) == 0 ? $urandom_range(0, 65535)
                                                 : $urandom_range(0, 20));
    endfunction

    function automatic tree_op_t random_op();
        int r, k;
        logic [2:0] kind;
        r = $urandom_range(0, 99);
        if (r < 30) return random_load();
        if (r < 32) return query_op(KIND_BUILD, $urandom, $urandom, $urandom);
        if (r < 35) return query_op($urandom_range(5, 7), $urandom, $urandom, $urandom);
        kind = r < 57 ? KIND_LCA : (r < 79 ? KIND_UP : KIND_DIST);
        k = $urandom_range(0, 3) == 0 ? $urandom_range(0, 1023) : $urandom_range(0, 12);
        return query_op(kind, pick_node($urandom_range(0, 9) == 0),
                        pick_node($urandom_range(0, 9) == 0), k);
    endfunction

    // result side: random stalls between beats while idle_on is set
    initial begin
        int gap;
        m_tready <= 1'b0;
        @(posedge aclk);
        while (!aresetn) @(posedge aclk);
        forever begin
            gap = idle_on ? $urandom_range(0, 15) : 0;
            if (gap > 0) begin
                m_tready <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (!m_tvalid);
            tree_sb.check_result('{rnode: m_tdata[10:0], found: m_tuser[0],
                                   path_len: m_tdata[37:11], err: m_tuser[1]});
        end
    end

    initial begin
        int bases[7];
        int counts[7];
        tree_sb   = new();
        idle_on   = 1;
        aresetn   <= 1'b0;
        s_tvalid  <= 1'b0;
        s_tdata   <= '0;
        s_tuser   <= '0;
        cfg_valid <= 1'b0;
        cfg_index <= CFG_INDEX_BASE;
        cfg_data  <= '0;
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;

        // directed: a small weighted tree with extreme weights
        send_op(load_op(0, 0, 1, 0));
        send_op(load_op(1, 0, 0, 65535));
        send_op(load_op(2, 1, 0, 65535));
        send_op(load_op(3, 0, 0, 0));
        send_op(load_op(1023, 2, 0, 1));
        send_op(load_op(500, 0, 1, 7));
        send_op(query_op(KIND_LCA, 1023, 3, 0));
        send_op(query_op(KIND_BUILD, 0, 0, 0));
        send_op(query_op(KIND_LCA, 1023, 3, 0));
        send_op(query_op(KIND_DIST, 1023, 3, 0));
        send_op(query_op(KIND_DIST, 2, 1023, 0));
        send_op(query_op(KIND_LCA, 500, 2, 0));
        send_op(query_op(KIND_DIST, 500, 2, 0));
        send_op(query_op(KIND_UP, 1023, 0, 0));
        send_op(query_op(KIND_UP, 1023, 0, 3));
        send_op(query_op(KIND_UP, 1023, 0, 4));
        send_op(query_op(KIND_UP, 1023, 0, 1023));
        send_op(query_op(KIND_UP, 1023, 0, 512));
        send_op(query_op(KIND_LCA, 1024, 3, 0));
        send_op(query_op(KIND_DIST, 2, 2047, 0));
        send_op(query_op(KIND_UP, 2047, 0, 1));
        send_op(load_op(1024, 0, 1, 0));
        send_op(load_op(5, 1500, 0, 3));
        send_op(query_op(3'd5, 2047, 2047, 1023));
        send_op(query_op(3'd7, 0, 0, 0));

        // random phases over several ranges, extremes included
        bases  = '{1, 1, 0, 0, 1, 0, 0};
        counts = '{1024, 1, 0, 2047, 300, 57, 1024};
        foreach (bases[ph]) begin
            set_range(bases[ph], counts[ph]);
            idle_on = (ph != 3);
            for (int n = 0; n < 20; n++) send_op(random_load());
            send_op(query_op(KIND_BUILD, 0, 0, 0));
            for (int n = 0; n < 40; n++) send_op(random_op());
        end

        wait_drained();
        repeat (100) @(posedge aclk);
        if (tree_sb.mismatches == 0 && tree_sb.pending.size() == 0) begin
            $display("lca_binary_lifting_top regression: pass");
        end else begin
            $display("lca_binary_lifting_top regression: fail");
        end
        $finish;
    end

endmodule
